FILE: design/tfpc_pkg.sv
// Shared types, constants and helpers for the five-point touch calibrator.
// No dependencies; every other design file imports this package.
package tfpc_pkg;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned TAPS     = 5;
  localparam int unsigned DVD_W    = 42;
  localparam int unsigned DVS_W    = 32;
  localparam int unsigned MAP_W    = 26;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned SPAN_W   = 27;
  localparam int unsigned DIFF_W   = 45;

  localparam logic [IDX_W-1:0] CFG_TARGET_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TARGET_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_TARGET_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_TARGET_BOTTOM = 3'd3;
  localparam logic [IDX_W-1:0] CFG_DISPLAY_MAX   = 3'd4;

  localparam logic [CFG_W-1:0] RST_TARGET_LEFT   = 10'd40;
  localparam logic [CFG_W-1:0] RST_TARGET_RIGHT  = 10'd200;
  localparam logic [CFG_W-1:0] RST_TARGET_TOP    = 10'd40;
  localparam logic [CFG_W-1:0] RST_TARGET_BOTTOM = 10'd200;
  localparam logic [CFG_W-1:0] RST_DISPLAY_MAX   = 10'd239;

  localparam logic [IDX_W-1:0] LAST_TAP   = 3'd4;
  localparam logic [IDX_W-1:0] DONE_COUNT = 3'd5;

  localparam logic signed [SPAN_W-1:0] SPAN_EPS = 27'sd65;
  localparam logic signed [31:0]       SCALE_ONE = 32'sd65536;

  typedef enum logic [1:0] {
    DIV_MAP    = 2'd0,
    DIV_SCALE  = 2'd1,
    DIV_OFFSET = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic             store_en;
    logic [IDX_W-1:0] store_idx;
    logic             swap_en;
    logic             prep_en;
    logic             axis;
    logic             acc_clr;
    logic [1:0]       pt;
    logic             div_go;
    div_sel_e         div_sel;
    logic             map_acc;
    logic             span_en;
    logic             scl_sat;
    logic             off_diff;
    logic             wr_unit;
    logic             wr_zero;
    logic             wr_full;
  } cal_cmd_t;

  typedef struct packed {
    logic div_done;
    logic span_small;
    logic scale_zero;
  } cal_sts_t;

  // Sample index of mapping point pt (two near points, then two far points).
  function automatic logic [IDX_W-1:0] pt_index(input logic axis, input logic [1:0] pt);
    logic [IDX_W-1:0] idx;
    idx = 3'd0;
    case (pt)
      2'd0: idx = 3'd0;
      2'd1: idx = axis ? 3'd1 : 3'd3;
      2'd2: idx = axis ? 3'd3 : 3'd1;
      2'd3: idx = 3'd2;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

FILE: design/tfpc_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tfpc_pkg for operand widths.
module tfpc_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tfpc_pkg::DVD_W-1:0] dividend_i,
  input  logic [tfpc_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tfpc_pkg::DVD_W-1:0] quotient_o
);
  import tfpc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than a cycle");
`endif

endmodule

FILE: design/tfpc_datapath.sv
// Datapath: configuration registers, sample store, axis fit arithmetic.
// Depends on tfpc_pkg and tfpc_divider.
module tfpc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfpc_pkg::cal_cmd_t              cmd_i,
  output tfpc_pkg::cal_sts_t              sts_o,
  input  logic                            cfg_we_i,
  input  logic [tfpc_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [tfpc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [tfpc_pkg::RAW_W-1:0]      raw_x_i,
  input  logic [tfpc_pkg::RAW_W-1:0]      raw_y_i,
  output logic [tfpc_pkg::RAW_W-1:0]      min_x_o,
  output logic [tfpc_pkg::RAW_W-1:0]      max_x_o,
  output logic [tfpc_pkg::RAW_W-1:0]      min_y_o,
  output logic [tfpc_pkg::RAW_W-1:0]      max_y_o,
  output logic                            invert_x_o,
  output logic                            invert_y_o,
  output logic                            swap_xy_o,
  output logic signed [15:0]              offset_x_o,
  output logic signed [15:0]              offset_y_o,
  output logic signed [31:0]              scale_x_o,
  output logic signed [31:0]              scale_y_o
);
  import tfpc_pkg::*;

  logic [CFG_W-1:0] t_left_q, t_right_q, t_top_q, t_bottom_q, dmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_left_q   <= RST_TARGET_LEFT;
      t_right_q  <= RST_TARGET_RIGHT;
      t_top_q    <= RST_TARGET_TOP;
      t_bottom_q <= RST_TARGET_BOTTOM;
      dmax_q     <= RST_DISPLAY_MAX;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TARGET_LEFT:   t_left_q   <= cfg_data_i;
        CFG_TARGET_RIGHT:  t_right_q  <= cfg_data_i;
        CFG_TARGET_TOP:    t_top_q    <= cfg_data_i;
        CFG_TARGET_BOTTOM: t_bottom_q <= cfg_data_i;
        CFG_DISPLAY_MAX:   dmax_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample store, no reset: all five entries are written before use.
  logic [RAW_W-1:0] sx_q [TAPS];
  logic [RAW_W-1:0] sy_q [TAPS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      sx_q[cmd_i.store_idx] <= raw_x_i;
      sy_q[cmd_i.store_idx] <= raw_y_i;
    end
  end

  // Axis swap from the horizontal pair differences.
  logic [RAW_W:0] dsx, dsy;
  logic           swap_q;

  function automatic logic [RAW_W-1:0] absdiff(input logic [RAW_W-1:0] a,
                                               input logic [RAW_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    dsx = {1'b0, absdiff(sx_q[1], sx_q[0])} + {1'b0, absdiff(sx_q[2], sx_q[3])};
    dsy = {1'b0, absdiff(sy_q[1], sy_q[0])} + {1'b0, absdiff(sy_q[2], sy_q[3])};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.swap_en) swap_q <= dsy > dsx;
  end

  // Screen-axis values, limits and inversion.
  logic [RAW_W-1:0] ax_q [TAPS];
  logic [RAW_W-1:0] ay_q [TAPS];
  logic [RAW_W-1:0] ax_d [TAPS];
  logic [RAW_W-1:0] ay_d [TAPS];
  logic [RAW_W-1:0] mnx_d, mxx_d, mny_d, mxy_d;
  logic [RAW_W-1:0] mnx_q, mxx_q, mny_q, mxy_q;
  logic             invx_q, invy_q;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      ax_d[i] = swap_q ? sy_q[i] : sx_q[i];
      ay_d[i] = swap_q ? sx_q[i] : sy_q[i];
    end
    mnx_d = ax_d[0];
    mxx_d = ax_d[0];
    mny_d = ay_d[0];
    mxy_d = ay_d[0];
    for (int i = 1; i < TAPS; i++) begin
      if (ax_d[i] < mnx_d) mnx_d = ax_d[i];
      if (ax_d[i] > mxx_d) mxx_d = ax_d[i];
      if (ay_d[i] < mny_d) mny_d = ay_d[i];
      if (ay_d[i] > mxy_d) mxy_d = ay_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_en) begin
      for (int i = 0; i < TAPS; i++) begin
        ax_q[i] <= ax_d[i];
        ay_q[i] <= ay_d[i];
      end
      mnx_q  <= mnx_d;
      mxx_q  <= mxx_d;
      mny_q  <= mny_d;
      mxy_q  <= mxy_d;
      invx_q <= ({1'b0, ax_d[0]} + {1'b0, ax_d[3]}) > ({1'b0, ax_d[1]} + {1'b0, ax_d[2]});
      invy_q <= ({1'b0, ay_d[0]} + {1'b0, ay_d[1]}) > ({1'b0, ay_d[3]} + {1'b0, ay_d[2]});
    end
  end

  // Per-axis operand selection.
  logic [RAW_W-1:0] lo, hi, v;
  logic             inv, degen;
  logic [CFG_W-1:0] t_near, t_far;
  logic [IDX_W-1:0] vidx;

  always_comb begin
    vidx   = pt_index(cmd_i.axis, cmd_i.pt);
    lo     = cmd_i.axis ? mny_q : mnx_q;
    hi     = cmd_i.axis ? mxy_q : mxx_q;
    inv    = cmd_i.axis ? invy_q : invx_q;
    t_near = cmd_i.axis ? t_top_q : t_left_q;
    t_far  = cmd_i.axis ? t_bottom_q : t_right_q;
    v      = cmd_i.axis ? ay_q[vidx] : ax_q[vidx];
    degen  = hi <= lo;
  end

  // Divider operands.
  logic [DVD_W-1:0]         div_a, quot;
  logic [DVS_W-1:0]         div_b;
  logic [MAP_W-1:0]         map_prod;
  logic signed [CFG_W:0]    span_t;
  logic [CFG_W:0]           span_t_abs;
  logic signed [SPAN_W-1:0] span_q;
  logic [SPAN_W-1:0]        span_abs;
  logic signed [31:0]       scl_q;
  logic [31:0]              scl_abs;
  logic                     neg_q;
  logic                     div_done;

  always_comb begin
    map_prod   = MAP_W'(v - lo) * MAP_W'(dmax_q);
    span_t     = $signed({1'b0, t_far}) - $signed({1'b0, t_near});
    span_t_abs = span_t[CFG_W] ? CFG_W'(-span_t) : span_t;
    span_abs   = span_q[SPAN_W-1] ? SPAN_W'(-span_q) : span_q;
    scl_abs    = scl_q[31] ? 32'(-scl_q) : scl_q;
    div_a      = '0;
    div_b      = '0;
    case (cmd_i.div_sel)
      DIV_MAP: begin
        div_a = {map_prod, 16'b0};
        div_b = DVS_W'(hi - lo);
      end
      DIV_SCALE: begin
        div_a = {span_t_abs[CFG_W-1:0], 32'b0};
        div_b = DVS_W'(span_abs);
      end
      DIV_OFFSET: begin
        div_a = {t_near, 32'b0};
        div_b = scl_abs;
      end
      default: ;
    endcase
  end

  tfpc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Mapping accumulation and span.
  logic [SUM_W-1:0] near_q, far_q;
  logic [MAP_W-1:0] m_val, full_q;

  always_comb begin
    full_q = {dmax_q, 16'b0};
    if (degen)    m_val = '0;
    else if (inv) m_val = full_q - quot[MAP_W-1:0];
    else          m_val = quot[MAP_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      near_q <= '0;
      far_q  <= '0;
    end else if (cmd_i.map_acc) begin
      if (!cmd_i.pt[1]) near_q <= near_q + SUM_W'(m_val);
      else              far_q  <= far_q + SUM_W'(m_val);
    end
    if (cmd_i.span_en)
      span_q <= $signed({1'b0, far_q[SUM_W-1:1]}) - $signed({1'b0, near_q[SUM_W-1:1]});
  end

  // Scale saturation and offset arithmetic.
  logic signed [31:0]       scl_d;
  logic signed [DVD_W+1:0]  q_signed;
  logic signed [DIFF_W-1:0] diff_q;
  logic [DIFF_W-1:0]        diff_abs;
  logic [DIFF_W-16:0]       rnd_mag;
  logic signed [15:0]       off_rnd;

  always_comb begin
    if (!neg_q) scl_d = (quot > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
    else        scl_d = (quot > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(quot[31:0]);
    q_signed = neg_q ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
    diff_abs = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : diff_q;
    rnd_mag  = (DIFF_W-15)'((diff_abs + DIFF_W'(32768)) >> 16);
    if (!diff_q[DIFF_W-1])
      off_rnd = (rnd_mag > (DIFF_W-15)'(32767)) ? 16'sh7FFF : $signed(rnd_mag[15:0]);
    else
      off_rnd = (rnd_mag > (DIFF_W-15)'(32768)) ? 16'sh8000 : -$signed(rnd_mag[15:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go && cmd_i.div_sel == DIV_SCALE) neg_q <= span_t[CFG_W] ^ span_q[SPAN_W-1];
    if (cmd_i.div_go && cmd_i.div_sel == DIV_OFFSET) neg_q <= scl_q[31];
    if (cmd_i.scl_sat) scl_q <= scl_d;
    if (cmd_i.off_diff)
      diff_q <= DIFF_W'(q_signed) - $signed({{(DIFF_W-MAP_W){1'b0}}, near_q[SUM_W-1:1]});
  end

  // Result registers.
  logic signed [31:0] scale_x_q, scale_y_q;
  logic signed [15:0] off_x_q, off_y_q;
  logic signed [31:0] scl_wr;
  logic signed [15:0] off_wr;
  logic               wr_any;

  always_comb begin
    wr_any = cmd_i.wr_unit | cmd_i.wr_zero | cmd_i.wr_full;
    scl_wr = cmd_i.wr_unit ? SCALE_ONE : scl_q;
    if (cmd_i.wr_unit)      off_wr = '0;
    else if (cmd_i.wr_zero) off_wr = (t_near != '0) ? 16'sh7FFF : 16'sh0000;
    else                    off_wr = off_rnd;
  end

  always_ff @(posedge clk_i) begin
    if (wr_any && !cmd_i.axis) begin
      scale_x_q <= scl_wr;
      off_x_q   <= off_wr;
    end
    if (wr_any && cmd_i.axis) begin
      scale_y_q <= scl_wr;
      off_y_q   <= off_wr;
    end
  end

  assign sts_o.div_done   = div_done;
  assign sts_o.span_small = (span_q <= SPAN_EPS) && (span_q >= -SPAN_EPS);
  assign sts_o.scale_zero = scl_q == '0;

  assign min_x_o    = mnx_q;
  assign max_x_o    = mxx_q;
  assign min_y_o    = mny_q;
  assign max_y_o    = mxy_q;
  assign invert_x_o = invx_q;
  assign invert_y_o = invy_q;
  assign swap_xy_o  = swap_q;
  assign offset_x_o = off_x_q;
  assign offset_y_o = off_y_q;
  assign scale_x_o  = scale_x_q;
  assign scale_y_o  = scale_y_q;

endmodule

FILE: design/tfpc_ctrl.sv
// Controller: tap collection, fit sequencing and result handshake.
// Depends on tfpc_pkg; drives the datapath by command, reads its status.
module tfpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfpc_pkg::cal_cmd_t cmd_o,
  input  tfpc_pkg::cal_sts_t sts_i
);
  import tfpc_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_SWAP     = 16'h0002,
    S_PREP     = 16'h0004,
    S_AXIS     = 16'h0008,
    S_MAP_GO   = 16'h0010,
    S_MAP_WAIT = 16'h0020,
    S_SPAN     = 16'h0040,
    S_SPAN_CHK = 16'h0080,
    S_SCL_GO   = 16'h0100,
    S_SCL_WAIT = 16'h0200,
    S_SCL_SAT  = 16'h0400,
    S_SCL_CHK  = 16'h0800,
    S_OFF_GO   = 16'h1000,
    S_OFF_WAIT = 16'h2000,
    S_OFF_DIFF = 16'h4000,
    S_OFF_RND  = 16'h8000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] tap_q, tap_d;
  logic             fin_q, fin_d;
  logic             axis_q, axis_d;
  logic [1:0]       pt_q, pt_d;
  logic             ov_q, ov_d;
  logic             accept;
  logic             axis_end;

  always_comb begin
    // Hold the fifth tap back while the previous result waits.
    in_ready_o = (state_q == S_IDLE) && !(ov_q && !fin_q && tap_q == LAST_TAP);
    accept     = in_valid_i && in_ready_o;

    state_d  = state_q;
    tap_d    = tap_q;
    fin_d    = fin_q;
    axis_d   = axis_q;
    pt_d     = pt_q;
    ov_d     = ov_q && !out_ready_i;
    axis_end = 1'b0;

    cmd_o           = '0;
    cmd_o.store_idx = tap_q;
    cmd_o.axis      = axis_q;
    cmd_o.pt        = pt_q;
    cmd_o.div_sel   = DIV_MAP;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (fin_q) begin
            fin_d = 1'b0;
            tap_d = '0;
          end else begin
            cmd_o.store_en = 1'b1;
            tap_d = tap_q + 1'b1;
            if (tap_q == LAST_TAP) begin
              fin_d   = 1'b1;
              state_d = S_SWAP;
            end
          end
        end
      end
      S_SWAP: begin
        cmd_o.swap_en = 1'b1;
        axis_d  = 1'b0;
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep_en = 1'b1;
        state_d = S_AXIS;
      end
      S_AXIS: begin
        cmd_o.acc_clr = 1'b1;
        pt_d    = '0;
        state_d = S_MAP_GO;
      end
      S_MAP_GO: begin
        cmd_o.div_go = 1'b1;
        state_d = S_MAP_WAIT;
      end
      S_MAP_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.map_acc = 1'b1;
          pt_d    = pt_q + 1'b1;
          state_d = (pt_q == 2'd3) ? S_SPAN : S_MAP_GO;
        end
      end
      S_SPAN: begin
        cmd_o.span_en = 1'b1;
        state_d = S_SPAN_CHK;
      end
      S_SPAN_CHK: begin
        if (sts_i.span_small) begin
          cmd_o.wr_unit = 1'b1;
          axis_end = 1'b1;
        end else begin
          state_d = S_SCL_GO;
        end
      end
      S_SCL_GO: begin
        cmd_o.div_sel = DIV_SCALE;
        cmd_o.div_go  = 1'b1;
        state_d = S_SCL_WAIT;
      end
      S_SCL_WAIT: begin
        if (sts_i.div_done) state_d = S_SCL_SAT;
      end
      S_SCL_SAT: begin
        cmd_o.scl_sat = 1'b1;
        state_d = S_SCL_CHK;
      end
      S_SCL_CHK: begin
        if (sts_i.scale_zero) begin
          cmd_o.wr_zero = 1'b1;
          axis_end = 1'b1;
        end else begin
          state_d = S_OFF_GO;
        end
      end
      S_OFF_GO: begin
        cmd_o.div_sel = DIV_OFFSET;
        cmd_o.div_go  = 1'b1;
        state_d = S_OFF_WAIT;
      end
      S_OFF_WAIT: begin
        if (sts_i.div_done) state_d = S_OFF_DIFF;
      end
      S_OFF_DIFF: begin
        cmd_o.off_diff = 1'b1;
        state_d = S_OFF_RND;
      end
      S_OFF_RND: begin
        cmd_o.wr_full = 1'b1;
        axis_end = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase

    // Advance to the second axis, or present the result.
    if (axis_end) begin
      if (axis_q) begin
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end else begin
        axis_d  = 1'b1;
        state_d = S_AXIS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= '0;
      fin_q   <= 1'b0;
      axis_q  <= 1'b0;
      pt_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      fin_q   <= fin_d;
      axis_q  <= axis_d;
      pt_q    <= pt_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

`ifndef ASSERT_OFF
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> state_q == S_IDLE) else $error("result shown while fitting");
  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q == (tap_q == DONE_COUNT)) else $error("finished flag and tap count disagree");
  a_fit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> $past(accept) && !ov_q) else $error("fit started without fifth tap");
`endif

endmodule

FILE: design/touch_five_point_calibrator.sv
// Five-point touch calibrator, top level; needs tfpc_pkg, tfpc_ctrl and tfpc_datapath.
// After the fifth tap transfer the fit sets swap and limits, then per axis runs four
// mappings, a scale and an offset division on the one shared divider, plus sequencing;
// a small span skips the scale and offset, a zero scale skips the offset. No taps are
// taken during a fit; after a result, the first tap transfer only restarts collection.
// Reset (rst_ni, async, low) clears collection and the result flag, sets config defaults.
module touch_five_point_calibrator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tap input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tfpc_pkg::RAW_W-1:0] raw_x_i,
  input  logic [tfpc_pkg::RAW_W-1:0] raw_y_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tfpc_pkg::RAW_W-1:0] min_x_o,
  output logic [tfpc_pkg::RAW_W-1:0] max_x_o,
  output logic [tfpc_pkg::RAW_W-1:0] min_y_o,
  output logic [tfpc_pkg::RAW_W-1:0] max_y_o,
  output logic                       invert_x_o,
  output logic                       invert_y_o,
  output logic                       swap_xy_o,
  output logic signed [15:0]         offset_x_o,
  output logic signed [15:0]         offset_y_o,
  output logic signed [31:0]         scale_x_o,
  output logic signed [31:0]         scale_y_o,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tfpc_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [tfpc_pkg::CFG_W-1:0] cfg_data_i
);
  import tfpc_pkg::*;

  cal_cmd_t cmd;
  cal_sts_t sts;

  // Registers take a transfer in any cycle; hold them steady while a fit runs.
  assign cfg_ready_o = 1'b1;

  tfpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tfpc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .min_x_o     (min_x_o),
    .max_x_o     (max_x_o),
    .min_y_o     (min_y_o),
    .max_y_o     (max_y_o),
    .invert_x_o  (invert_x_o),
    .invert_y_o  (invert_y_o),
    .swap_xy_o   (swap_xy_o),
    .offset_x_o  (offset_x_o),
    .offset_y_o  (offset_y_o),
    .scale_x_o   (scale_x_o),
    .scale_y_o   (scale_y_o)
  );

endmodule
